@@ rtl/core/rmq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_W          = 18;
    localparam int W_W           = 17;
    localparam int Q_W           = 18;
    localparam int LANES         = 4;

    localparam int LANE_W = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Y = 2;
    localparam int LANE_Z = 3;

    localparam logic [W_W-1:0] MAG_MAX = '1;

    typedef struct packed {
        logic x_pos;
        logic x_neg;
        logic y_pos;
        logic y_neg;
        logic z_pos;
        logic z_neg;
    } rmq_sign_t;

    // signed width of one +/- three matrix entries
    function automatic int sum_w(input int f);
        return ((f > 19) ? f : 19) + 2;
    endfunction

    // bits of the integer root of |sum| * 2^(f-2)
    function automatic int root_w(input int f);
        return ((sum_w(f) - 1) + (f - 2) + 1) >> 1;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rmq_root4.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rmq_root4 #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [2*rmq_pkg::root_w(FRAC_BITS)-1:0] in_rad [rmq_pkg::LANES],
    input  rmq_pkg::rmq_sign_t    in_sign,
    output logic                  out_valid,
    output logic [rmq_pkg::root_w(FRAC_BITS):0]     out_root [rmq_pkg::LANES],
    output rmq_pkg::rmq_sign_t    out_sign
);
    import rmq_pkg::*;

    localparam int ROOT_W = root_w(FRAC_BITS);
    localparam int RAD2_W = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    logic              vld_reg  [ROOT_W];
    rmq_sign_t         sign_reg [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W][LANES];
    logic [ROOT_W-1:0] q_reg    [ROOT_W][LANES];
    logic [RAD2_W-1:0] rad_reg  [ROOT_W][LANES];

    logic              done_vld_reg;
    rmq_sign_t         done_sign_reg;
    logic [ROOT_W:0]   root_reg [LANES];

    genvar k, l;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stage
            logic      vld_src;
            rmq_sign_t sign_src;

            if (k == 0) begin : g_head
                assign vld_src  = in_valid;
                assign sign_src = in_sign;
            end
            else begin : g_body
                assign vld_src  = vld_reg[k-1];
                assign sign_src = sign_reg[k-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else
                begin
                    vld_reg[k] <= vld_src;
                end
            end

            always_ff @(posedge clk)
            begin
                sign_reg[k] <= sign_src;
            end

            for (l = 0; l < LANES; l++) begin : g_lane
                logic [REM_W-1:0]  rem_src;
                logic [ROOT_W-1:0] q_src;
                logic [RAD2_W-1:0] rad_src;
                logic [REM_W-1:0]  cur;
                logic [REM_W-1:0]  trial;
                logic              ge;
                logic [REM_W-1:0]  rem_next;
                logic [ROOT_W-1:0] q_next;
                logic [RAD2_W-1:0] rad_next;

                if (k == 0) begin : g_head
                    assign rem_src = '0;
                    assign q_src   = '0;
                    assign rad_src = in_rad[l];
                end
                else begin : g_body
                    assign rem_src = rem_reg[k-1][l];
                    assign q_src   = q_reg[k-1][l];
                    assign rad_src = rad_reg[k-1][l];
                end

                // bring down two radicand bits, try q:01
                assign cur      = {rem_src[REM_W-3:0], rad_src[RAD2_W-1 -: 2]};
                assign trial    = {q_src, 2'b01};
                assign ge       = (cur >= trial);
                assign rem_next = ge ? (cur - trial) : cur;
                assign q_next   = {q_src[ROOT_W-2:0], ge};
                assign rad_next = {rad_src[RAD2_W-3:0], 2'b00};

                always_ff @(posedge clk)
                begin
                    rem_reg[k][l] <= rem_next;
                    q_reg[k][l]   <= q_next;
                    rad_reg[k][l] <= rad_next;
                end
            end
        end

        for (l = 0; l < LANES; l++) begin : g_round
            logic [ROOT_W:0] root_next;

            // round up when the remainder exceeds the root
            assign root_next = (ROOT_W+1)'(q_reg[ROOT_W-1][l])
                + (ROOT_W+1)'(rem_reg[ROOT_W-1][l] > REM_W'(q_reg[ROOT_W-1][l]));

            always_ff @(posedge clk)
            begin
                root_reg[l] <= root_next;
            end

            assign out_root[l] = root_reg[l];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_vld_reg <= 1'b0;
        end
        else
        begin
            done_vld_reg <= vld_reg[ROOT_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        done_sign_reg <= sign_reg[ROOT_W-1];
    end

    assign out_valid = done_vld_reg;
    assign out_sign  = done_sign_reg;

    a_vld_from_in : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, ROOT_W + 1))
        else $error("root word without an input word");

    a_in_to_vld : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##(ROOT_W + 1) out_valid)
        else $error("input word lost in root pipeline");

    generate
        for (l = 0; l < LANES; l++) begin : g_chk
            a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
                vld_reg[ROOT_W-1] |->
                    rem_reg[ROOT_W-1][l] <= REM_W'({q_reg[ROOT_W-1][l], 1'b0}))
                else $error("root remainder above twice the root");
        end
    endgenerate

endmodule

`default_nettype wire

@@ rtl/core/rotation_matrix_to_quaternion.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Rotation matrix to quaternion, fully pipelined.
// Input: nine signed Q2.16 entries m11..m33, taken at a rising edge with
// start high and busy low. busy is held low: a new matrix may be given in
// every cycle.
// Output: quat_w (unsigned Q1.16) and quat_x/y/z (signed Q2.16), valid for the
// single cycle that done is high. Results leave in the order of entry.
// Each matrix passes the sum, magnitude, square root, rounding and sign
// registers in that order. The square root is digit by digit, one result
// bit per stage, four roots side by side.
// Throughput: one matrix per cycle.
// Reset clears the valid bits only; no result is given until a matrix is
// accepted. The receiver cannot stall: each word is shown once for one cycle.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [rmq_pkg::IN_W-1:0]   m11,
    input  logic signed [rmq_pkg::IN_W-1:0]   m12,
    input  logic signed [rmq_pkg::IN_W-1:0]   m13,
    input  logic signed [rmq_pkg::IN_W-1:0]   m21,
    input  logic signed [rmq_pkg::IN_W-1:0]   m22,
    input  logic signed [rmq_pkg::IN_W-1:0]   m23,
    input  logic signed [rmq_pkg::IN_W-1:0]   m31,
    input  logic signed [rmq_pkg::IN_W-1:0]   m32,
    input  logic signed [rmq_pkg::IN_W-1:0]   m33,
    output logic                              done,
    output logic        [rmq_pkg::W_W-1:0]    quat_w,
    output logic signed [rmq_pkg::Q_W-1:0]    quat_x,
    output logic signed [rmq_pkg::Q_W-1:0]    quat_y,
    output logic signed [rmq_pkg::Q_W-1:0]    quat_z
);
    import rmq_pkg::*;

    localparam int SUM_W  = sum_w(FRAC_BITS);
    localparam int ABS_W  = SUM_W - 1;
    localparam int ROOT_W = root_w(FRAC_BITS);
    localparam int RAD2_W = 2 * ROOT_W;
    localparam int CMP_W  = (ROOT_W + 1 > W_W) ? ROOT_W + 1 : W_W;
    localparam int LAT    = ROOT_W + 4;

    localparam logic signed [SUM_W-1:0] ONE =
        {{(SUM_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W - 1){1'b0}}};

    logic                     accept;
    logic signed [SUM_W-1:0]  e11, e22, e33;
    logic signed [SUM_W-1:0]  sum_next [LANES];
    rmq_sign_t                sign_next;

    logic                     s1_vld_reg;
    logic signed [SUM_W-1:0]  sum_reg [LANES];
    rmq_sign_t                s1_sign_reg;

    logic                     s2_vld_reg;
    logic [RAD2_W-1:0]        rad_reg [LANES];
    rmq_sign_t                s2_sign_reg;

    logic                     rt_vld;
    logic [ROOT_W:0]          rt_root [LANES];
    rmq_sign_t                rt_sign;

    logic [W_W-1:0]           mag [LANES];
    logic [Q_W-1:0]           mag_q [LANES];
    logic [Q_W-1:0]           x_next, y_next, z_next;

    logic                     done_reg;
    logic [W_W-1:0]           w_reg;
    logic [Q_W-1:0]           x_reg, y_reg, z_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign e11 = SUM_W'(m11);
    assign e22 = SUM_W'(m22);
    assign e33 = SUM_W'(m33);

    assign sum_next[LANE_W] = ONE + e11 + e22 + e33;
    assign sum_next[LANE_X] = ONE + e11 - e22 - e33;
    assign sum_next[LANE_Y] = ONE - e11 + e22 - e33;
    assign sum_next[LANE_Z] = ONE - e11 - e22 + e33;

    assign sign_next.x_pos = (m32 > m23);
    assign sign_next.x_neg = (m32 < m23);
    assign sign_next.y_pos = (m13 > m31);
    assign sign_next.y_neg = (m13 < m31);
    assign sign_next.z_pos = (m21 > m12);
    assign sign_next.z_neg = (m21 < m12);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= rt_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sign_reg <= sign_next;
        s2_sign_reg <= s1_sign_reg;
    end

    genvar l;
    generate
        for (l = 0; l < LANES; l++) begin : g_front
            logic [ABS_W-1:0] abs_val;

            // take the magnitude and scale by 2^(FRAC_BITS-2)
            assign abs_val = sum_reg[l][SUM_W-1] ? ABS_W'(-sum_reg[l])
                                                 : ABS_W'(sum_reg[l]);

            always_ff @(posedge clk)
            begin
                sum_reg[l] <= sum_next[l];
                rad_reg[l] <= RAD2_W'(abs_val) << (FRAC_BITS - 2);
            end

            // clamp at the unsigned Q1.16 limit
            assign mag[l] = (CMP_W'(rt_root[l]) > CMP_W'(MAG_MAX)) ? MAG_MAX
                                                                   : W_W'(rt_root[l]);
            assign mag_q[l] = {1'b0, mag[l]};
        end
    endgenerate

    rmq_root4 #(
        .FRAC_BITS (FRAC_BITS)
    ) u_root4 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld_reg),
        .in_rad    (rad_reg),
        .in_sign   (s2_sign_reg),
        .out_valid (rt_vld),
        .out_root  (rt_root),
        .out_sign  (rt_sign)
    );

    // negate on a positive difference, drop on a zero one
    assign x_next = rt_sign.x_pos ? (-mag_q[LANE_X]) :
                    rt_sign.x_neg ? mag_q[LANE_X] : '0;
    assign y_next = rt_sign.y_pos ? (-mag_q[LANE_Y]) :
                    rt_sign.y_neg ? mag_q[LANE_Y] : '0;
    assign z_next = rt_sign.z_pos ? (-mag_q[LANE_Z]) :
                    rt_sign.z_neg ? mag_q[LANE_Z] : '0;

    always_ff @(posedge clk)
    begin
        w_reg <= mag[LANE_W];
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done   = done_reg;
    assign quat_w = w_reg;
    assign quat_x = x_reg;
    assign quat_y = y_reg;
    assign quat_z = z_reg;

    a_start_to_done : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("accepted matrix gave no quaternion");

    a_done_from_start : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("quaternion without an accepted matrix");

    a_part_clamped : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (quat_x != Q_MIN) && (quat_y != Q_MIN) && (quat_z != Q_MIN))
        else $error("vector part beyond the clamped range");

endmodule

`default_nettype wire
